/* rtl/gnpm_pkg.sv */
// ----------------------------------------------------------------------------
// gnpm_pkg
// shared types and codes of the greedy nearest pair matcher
// ----------------------------------------------------------------------------
package gnpm_pkg;

    localparam int COORD_W = 16;
    localparam int COST_W  = 34;
    localparam int DIFF_W  = 17;
    localparam int SQ_W    = 33;
    localparam int OIDX_W  = 4;
    localparam int TIDX_W  = 3;

    typedef enum logic [1:0] {
        REQ_LOAD_OBS   = 2'd0,
        REQ_LOAD_TRACK = 2'd1,
        REQ_RUN        = 2'd2,
        REQ_NONE       = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_MATCH     = 2'd0,
        KIND_TRACK     = 2'd1,
        KIND_OBS       = 2'd2,
        KIND_EMPTY     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COST_RD,
        ST_COST_SQ,
        ST_COST_SUM,
        ST_COST_WR,
        ST_SCAN_RD,
        ST_SCAN,
        ST_DECIDE,
        ST_LEFT_TRK,
        ST_LEFT_OBS,
        ST_EMIT,
        ST_CLEAR
    } state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [OIDX_W-1:0] obs_index;
        logic [TIDX_W-1:0] track_index;
        logic              overflow;
        logic              last;
    } result_t;

    function automatic logic [SQ_W-1:0] sq_diff(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
        logic signed [DIFF_W-1:0]   d;
        logic signed [2*DIFF_W-1:0] p;
        d = DIFF_W'(a) - DIFF_W'(b);
        p = d * d;
        return p[SQ_W-1:0];
    endfunction

endpackage

/* rtl/greedy_nearest_pair_matcher.sv */
// ----------------------------------------------------------------------------
// greedy_nearest_pair_matcher
// loads points one beat per cycle while idle, then greedily matches cheapest pairs
// ----------------------------------------------------------------------------
// loads: one beat per cycle while idle, no result
// run: cost pass steps each pair through read, square, sum and write states,
//   each greedy pick walks the pair ram at 1 pair per cycle, then result beats
//   are pushed as the output register has room
// reset: counts, used bits, flag cleared at once; tables undefined until loaded
module greedy_nearest_pair_matcher #(
    parameter int MAX_OBS    = 16,
    parameter int MAX_TRACKS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // pos_x, pos_y, est_x, est_y
    input  logic [1:0]  s_tuser,    // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // obs_index, track_index, overflow
    output logic [1:0]  m_tuser,    // kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [33:0] cfg_wdata
);

    localparam int OW  = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
    localparam int TW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int OCW = $clog2(MAX_OBS + 1);
    localparam int TCW = $clog2(MAX_TRACKS + 1);
    localparam int PD  = (1 << OW) * (1 << TW);
    localparam int PW  = OW + TW;
    localparam int CW  = gnpm_pkg::COST_W;
    localparam int SW  = gnpm_pkg::SQ_W;

    gnpm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]         limit_reg;
    logic [OCW-1:0]        ocnt_reg, ocnt_next;
    logic [TCW-1:0]        tcnt_reg, tcnt_next;
    logic [MAX_OBS-1:0]    oused_reg, oused_next;
    logic [MAX_TRACKS-1:0] tused_reg, tused_next;
    logic                  drop_reg, drop_next;
    logic [OW-1:0]         oi_reg, oi_next, bi_reg, bi_next;
    logic [TW-1:0]         ti_reg, ti_next, bj_reg, bj_next;
    logic                  found_reg, found_next, lastp_reg, lastp_next;
    logic [CW-1:0]         best_reg, best_next;
    logic [SW-1:0]         s0_reg, s1_reg, s2_reg, s3_reg;
    logic [CW-1:0]         ca_reg, cb_reg;

    logic                  acc;
    gnpm_pkg::req_t        req;
    logic [31:0]           obs_rd;
    logic [63:0]           trk_rd;
    logic [CW-1:0]         cost_rd;
    logic                  owe, twe, cwe;
    logic [OW-1:0]         oraddr;
    logic [TW-1:0]         traddr;
    logic [PW-1:0]         craddr;
    logic                  push, ofull;
    gnpm_pkg::result_t     res, outd;

    assign req = gnpm_pkg::req_t'(s_tuser);
    assign s_tready = (state_reg == gnpm_pkg::ST_IDLE);
    assign acc = s_tvalid && s_tready;
    assign owe = acc && req == gnpm_pkg::REQ_LOAD_OBS && ocnt_reg < OCW'(MAX_OBS);
    assign twe = acc && req == gnpm_pkg::REQ_LOAD_TRACK && tcnt_reg < TCW'(MAX_TRACKS);

    gnpm_ram #(.WIDTH(32), .DEPTH(1 << OW)) u_obs (
        .clk(clk), .we(owe), .waddr(ocnt_reg[OW-1:0]), .wdata(s_tdata[31:0]),
        .raddr(oraddr), .rdata(obs_rd));
    gnpm_ram #(.WIDTH(64), .DEPTH(1 << TW)) u_trk (
        .clk(clk), .we(twe), .waddr(tcnt_reg[TW-1:0]), .wdata(s_tdata[63:0]),
        .raddr(traddr), .rdata(trk_rd));
    gnpm_ram #(.WIDTH(CW), .DEPTH(PD)) u_cost (
        .clk(clk), .we(cwe), .waddr({oi_reg, ti_reg}),
        .wdata((ca_reg < cb_reg) ? ca_reg : cb_reg),
        .raddr(craddr), .rdata(cost_rd));

    gnpm_out_reg u_out (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(res), .full(ofull),
        .tvalid(m_tvalid), .tready(m_tready), .data(outd));

    assign m_tuser = outd.kind;
    assign m_tdata = {outd.overflow, outd.track_index, outd.obs_index};
    assign m_tlast = outd.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gnpm_pkg::ST_IDLE;
            limit_reg <= CW'(256);
            ocnt_reg  <= '0;
            tcnt_reg  <= '0;
            oused_reg <= '0;
            tused_reg <= '0;
            drop_reg  <= 1'b0;
            oi_reg    <= '0;
            ti_reg    <= '0;
            bi_reg    <= '0;
            bj_reg    <= '0;
            found_reg <= 1'b0;
            lastp_reg <= 1'b0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            ocnt_reg  <= ocnt_next;
            tcnt_reg  <= tcnt_next;
            oused_reg <= oused_next;
            tused_reg <= tused_next;
            drop_reg  <= drop_next;
            oi_reg    <= oi_next;
            ti_reg    <= ti_next;
            bi_reg    <= bi_next;
            bj_reg    <= bj_next;
            found_reg <= found_next;
            lastp_reg <= lastp_next;
            best_reg  <= best_next;
        end
    end

    // squared distances, then sums, registered between steps
    always_ff @(posedge clk)
    begin
        s0_reg <= gnpm_pkg::sq_diff(obs_rd[15:0],  trk_rd[15:0]);
        s1_reg <= gnpm_pkg::sq_diff(obs_rd[31:16], trk_rd[31:16]);
        s2_reg <= gnpm_pkg::sq_diff(obs_rd[15:0],  trk_rd[47:32]);
        s3_reg <= gnpm_pkg::sq_diff(obs_rd[31:16], trk_rd[63:48]);
        ca_reg <= CW'(s0_reg) + CW'(s1_reg);
        cb_reg <= CW'(s2_reg) + CW'(s3_reg);
    end

    always_comb
    begin
        logic oend, tend, pend;
        state_next = state_reg;
        ocnt_next  = ocnt_reg;
        tcnt_next  = tcnt_reg;
        oused_next = oused_reg;
        tused_next = tused_reg;
        drop_next  = drop_reg;
        oi_next    = oi_reg;
        ti_next    = ti_reg;
        bi_next    = bi_reg;
        bj_next    = bj_reg;
        found_next = found_reg;
        lastp_next = lastp_reg;
        best_next  = best_reg;
        oraddr     = oi_reg;
        traddr     = ti_reg;
        craddr     = {oi_reg, ti_reg};
        cwe        = 1'b0;
        push       = 1'b0;
        res.kind        = gnpm_pkg::KIND_EMPTY;
        res.obs_index   = '0;
        res.track_index = '0;
        res.overflow    = drop_reg;
        res.last        = 1'b0;
        oend = ({1'b0, oi_reg} == OCW'(ocnt_reg - 1'b1));
        tend = ({1'b0, ti_reg} == TCW'(tcnt_reg - 1'b1));
        pend = oend && tend;

        unique case (state_reg)
            gnpm_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (req)
                        gnpm_pkg::REQ_LOAD_OBS:
                        begin
                            if (owe) ocnt_next = ocnt_reg + 1'b1;
                            else drop_next = 1'b1;
                        end
                        gnpm_pkg::REQ_LOAD_TRACK:
                        begin
                            if (twe) tcnt_next = tcnt_reg + 1'b1;
                            else drop_next = 1'b1;
                        end
                        gnpm_pkg::REQ_RUN:
                        begin
                            oi_next = '0;
                            ti_next = '0;
                            if (ocnt_reg == '0 && tcnt_reg == '0)
                                state_next = gnpm_pkg::ST_EMIT;
                            else if (ocnt_reg == '0 || tcnt_reg == '0)
                                state_next = gnpm_pkg::ST_LEFT_TRK;
                            else
                                state_next = gnpm_pkg::ST_COST_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            gnpm_pkg::ST_COST_RD:  state_next = gnpm_pkg::ST_COST_SQ;
            gnpm_pkg::ST_COST_SQ:  state_next = gnpm_pkg::ST_COST_SUM;
            gnpm_pkg::ST_COST_SUM: state_next = gnpm_pkg::ST_COST_WR;
            gnpm_pkg::ST_COST_WR:
            begin
                cwe = 1'b1;
                if (tend)
                begin
                    ti_next = '0;
                    oi_next = oi_reg + 1'b1;
                end
                else
                begin
                    ti_next = ti_reg + 1'b1;
                end
                if (pend)
                begin
                    oi_next = '0;
                    found_next = 1'b0;
                    state_next = gnpm_pkg::ST_SCAN_RD;
                end
                else
                begin
                    state_next = gnpm_pkg::ST_COST_RD;
                end
            end
            gnpm_pkg::ST_SCAN_RD:
            begin
                // issue read for current pair, step address
                lastp_next = pend;
                if (tend)
                begin
                    ti_next = '0;
                    oi_next = oi_reg + 1'b1;
                end
                else
                begin
                    ti_next = ti_reg + 1'b1;
                end
                bi_next = bi_reg;
                state_next = gnpm_pkg::ST_SCAN;
            end
            gnpm_pkg::ST_SCAN:
            begin
                // compare the pair read last cycle; its index is one behind
                logic [OW-1:0] po;
                logic [TW-1:0] pt;
                {po, pt} = PW'({oi_reg, ti_reg} - 1'b1);
                if (lastp_reg)
                begin
                    po = OW'(ocnt_reg - 1'b1);
                    pt = TW'(tcnt_reg - 1'b1);
                end
                else if (ti_reg == '0)
                begin
                    po = oi_reg - 1'b1;
                    pt = TW'(tcnt_reg - 1'b1);
                end
                else
                begin
                    po = oi_reg;
                    pt = ti_reg - 1'b1;
                end
                if (!oused_reg[po] && !tused_reg[pt] && (!found_reg || cost_rd < best_reg))
                begin
                    found_next = 1'b1;
                    best_next  = cost_rd;
                    bi_next    = po;
                    bj_next    = pt;
                end
                if (lastp_reg)
                begin
                    state_next = gnpm_pkg::ST_DECIDE;
                end
                else
                begin
                    lastp_next = pend;
                    if (tend)
                    begin
                        ti_next = '0;
                        oi_next = oi_reg + 1'b1;
                    end
                    else
                    begin
                        ti_next = ti_reg + 1'b1;
                    end
                end
            end
            gnpm_pkg::ST_DECIDE:
            begin
                oi_next = '0;
                ti_next = '0;
                if (!found_reg || best_reg > limit_reg)
                begin
                    state_next = gnpm_pkg::ST_LEFT_TRK;
                end
                else if (!ofull)
                begin
                    push = 1'b1;
                    res.kind = gnpm_pkg::KIND_MATCH;
                    res.obs_index = 4'(bi_reg);
                    res.track_index = 3'(bj_reg);
                    oused_next[bi_reg] = 1'b1;
                    tused_next[bj_reg] = 1'b1;
                    // last only if nothing remains afterwards
                    res.last = ($countones(oused_reg) + 1 == ocnt_reg) &&
                               ($countones(tused_reg) + 1 == tcnt_reg);
                    found_next = 1'b0;
                    if ($countones(oused_reg) + 1 == ocnt_reg ||
                        $countones(tused_reg) + 1 == tcnt_reg)
                        state_next = res.last ? gnpm_pkg::ST_CLEAR
                                              : gnpm_pkg::ST_LEFT_TRK;
                    else
                        state_next = gnpm_pkg::ST_SCAN_RD;
                end
            end
            gnpm_pkg::ST_LEFT_TRK:
            begin
                if ({1'b0, ti_reg} >= tcnt_reg || tcnt_reg == '0)
                begin
                    ti_next = '0;
                    state_next = gnpm_pkg::ST_LEFT_OBS;
                end
                else if (tused_reg[ti_reg])
                begin
                    ti_next = ti_reg + 1'b1;
                    if (tend) state_next = gnpm_pkg::ST_LEFT_OBS;
                end
                else if (!ofull)
                begin
                    push = 1'b1;
                    res.kind = gnpm_pkg::KIND_TRACK;
                    res.track_index = 3'(ti_reg);
                    // last if every observation is taken and no later free track exists
                    res.last = ($countones(oused_reg) == ocnt_reg);
                    for (int k = 0; k < MAX_TRACKS; k++)
                        if (k > int'(ti_reg) && k < int'(tcnt_reg) && !tused_reg[k])
                            res.last = 1'b0;
                    ti_next = ti_reg + 1'b1;
                    if (res.last)
                        state_next = gnpm_pkg::ST_CLEAR;
                    else if (tend)
                        state_next = gnpm_pkg::ST_LEFT_OBS;
                end
            end
            gnpm_pkg::ST_LEFT_OBS:
            begin
                if ({1'b0, oi_reg} >= ocnt_reg || ocnt_reg == '0)
                begin
                    state_next = gnpm_pkg::ST_CLEAR;
                end
                else if (oused_reg[oi_reg])
                begin
                    oi_next = oi_reg + 1'b1;
                    if (oend) state_next = gnpm_pkg::ST_CLEAR;
                end
                else if (!ofull)
                begin
                    push = 1'b1;
                    res.kind = gnpm_pkg::KIND_OBS;
                    res.obs_index = 4'(oi_reg);
                    // last unless a later free observation exists
                    res.last = 1'b1;
                    for (int k = 0; k < MAX_OBS; k++)
                        if (k > int'(oi_reg) && k < int'(ocnt_reg) && !oused_reg[k])
                            res.last = 1'b0;
                    oused_next[oi_reg] = 1'b1;
                    oi_next = oi_reg + 1'b1;
                    if (res.last) state_next = gnpm_pkg::ST_CLEAR;
                end
            end
            gnpm_pkg::ST_EMIT:
            begin
                if (!ofull)
                begin
                    push = 1'b1;
                    res.last = 1'b1;
                    state_next = gnpm_pkg::ST_CLEAR;
                end
            end
            gnpm_pkg::ST_CLEAR:
            begin
                ocnt_next  = '0;
                tcnt_next  = '0;
                oused_next = '0;
                tused_next = '0;
                drop_next  = 1'b0;
                oi_next    = '0;
                ti_next    = '0;
                state_next = gnpm_pkg::ST_IDLE;
            end
            default: state_next = gnpm_pkg::ST_IDLE;
        endcase
        if (state_reg == gnpm_pkg::ST_SCAN_RD || state_reg == gnpm_pkg::ST_SCAN)
            craddr = {oi_reg, ti_reg};
    end

endmodule

/* rtl/gnpm_ram.sv */
// ----------------------------------------------------------------------------
// gnpm_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module gnpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/gnpm_out_reg.sv */
// ----------------------------------------------------------------------------
// gnpm_out_reg
// one-entry output register for result beats
// ----------------------------------------------------------------------------
module gnpm_out_reg (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  gnpm_pkg::result_t        push_data,
    output logic                     full,
    output logic                     tvalid,
    input  logic                     tready,
    output gnpm_pkg::result_t        data
);

    logic              valid_reg;
    gnpm_pkg::result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    // push only when empty or draining this cycle
    assign full   = valid_reg && !tready;
    assign tvalid = valid_reg;
    assign data   = data_reg;

endmodule

/* rtl/gnpm_checker.sv */
// ----------------------------------------------------------------------------
// gnpm_checker
// port level checks of the matcher, bound to the top level
// ----------------------------------------------------------------------------
module gnpm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken mid run");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == gnpm_pkg::KIND_EMPTY |-> m_tlast)
        else $error("empty result not last");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == gnpm_pkg::KIND_EMPTY |-> m_tdata[6:0] == 7'd0)
        else $error("empty result carries indices");

endmodule

bind greedy_nearest_pair_matcher gnpm_checker u_gnpm_checker (
    .clk(clk), .rst_n(rst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast));

/* verif/greedy_nearest_pair_matcher_test.sv */
// ----------------------------------------------------------------------------
// greedy_nearest_pair_matcher_test
// self-checking bench: loads points, runs greedy matching and compares every
// result beat against an in-bench pair matcher under random idling and stalls
// ----------------------------------------------------------------------------
module greedy_nearest_pair_matcher_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_OBS    = 16;
    localparam int N_TRK    = 8;
    localparam int DOG_MAX  = 20000;
    localparam int SETTLE   = 40;
    localparam logic [33:0] LIMIT_MAX = 34'h3_FFFF_FFFF;

    typedef struct {
        gnpm_pkg::req_t    req;
        logic [15:0]       px, py, ex, ey;
        int                rep;
        bit                typed;
        gnpm_pkg::result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;     // pos_x, pos_y, est_x, est_y
    logic [1:0]  s_tuser;     // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;     // obs_index, track_index, overflow
    logic [1:0]  m_tuser;     // kind
    logic        m_tlast;
    logic        cfg_we;
    logic [33:0] cfg_wdata;

    greedy_nearest_pair_matcher #(
        .MAX_OBS    (N_OBS),
        .MAX_TRACKS (N_TRK)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // matcher copy of the block state
    logic signed [15:0] obs_x [N_OBS];
    logic signed [15:0] obs_y [N_OBS];
    logic signed [15:0] trk_px [N_TRK];
    logic signed [15:0] trk_py [N_TRK];
    logic signed [15:0] trk_ex [N_TRK];
    logic signed [15:0] trk_ey [N_TRK];
    int          n_obs, n_trk;
    bit          dropped;
    logic [33:0] dist_limit;

    gnpm_pkg::result_t pending_results[$];
    gnpm_pkg::result_t typed_results[$];
    int          errors, n_runs, n_results, n_matches;
    int          tx_idle_pct, rx_idle_pct;
    int          hold_req;
    int          idle_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input gnpm_pkg::result_t got,
                                   input gnpm_pkg::result_t want);
        errors++;
        $display("mismatch %s: got %0d/%0d/%0d/%0d/%0d, want %0d/%0d/%0d/%0d/%0d",
                 what, got.kind, got.obs_index, got.track_index, got.overflow, got.last,
                 want.kind, want.obs_index, want.track_index, want.overflow, want.last);
    endtask

    function automatic logic [33:0] sq_dist(input logic signed [15:0] ax,
                                            input logic signed [15:0] ay,
                                            input logic signed [15:0] bx,
                                            input logic signed [15:0] by);
        longint dx, dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return 34'(dx * dx + dy * dy);
    endfunction

    function automatic gnpm_pkg::result_t mk_result(input gnpm_pkg::kind_t k, input int oi,
                                                    input int ti);
        gnpm_pkg::result_t r;
        r.kind        = k;
        r.obs_index   = gnpm_pkg::OIDX_W'(oi);
        r.track_index = gnpm_pkg::TIDX_W'(ti);
        r.overflow    = dropped;
        r.last        = 1'b0;
        return r;
    endfunction

    task automatic match_step(input logic [1:0] req, input logic [63:0] d);
        logic [33:0]       pair_cost [N_OBS][N_TRK];
        logic [33:0]       a, b, best;
        bit                obs_taken [N_OBS];
        bit                trk_taken [N_TRK];
        gnpm_pkg::result_t run_q[$];
        bit                found;
        int                bi, bj, pairs;
        case (req)
            gnpm_pkg::REQ_LOAD_OBS:
                if (n_obs < N_OBS)
                begin
                    obs_x[n_obs] = d[15:0];
                    obs_y[n_obs] = d[31:16];
                    n_obs++;
                end
                else
                    dropped = 1'b1;
            gnpm_pkg::REQ_LOAD_TRACK:
                if (n_trk < N_TRK)
                begin
                    trk_px[n_trk] = d[15:0];
                    trk_py[n_trk] = d[31:16];
                    trk_ex[n_trk] = d[47:32];
                    trk_ey[n_trk] = d[63:48];
                    n_trk++;
                end
                else
                    dropped = 1'b1;
            gnpm_pkg::REQ_RUN:
            begin
                n_runs++;
                if (n_obs == 0 && n_trk == 0)
                    run_q.insert(run_q.size(), mk_result(gnpm_pkg::KIND_EMPTY, 0, 0));
                else
                begin
                    for (int i = 0; i < n_obs; i++)
                    begin
                        obs_taken[i] = 1'b0;
                        for (int j = 0; j < n_trk; j++)
                        begin
                            a = sq_dist(obs_x[i], obs_y[i], trk_px[j], trk_py[j]);
                            b = sq_dist(obs_x[i], obs_y[i], trk_ex[j], trk_ey[j]);
                            pair_cost[i][j] = (a < b) ? a : b;
                        end
                    end
                    for (int j = 0; j < n_trk; j++)
                        trk_taken[j] = 1'b0;
                    pairs = (n_obs < n_trk) ? n_obs : n_trk;
                    for (int m = 0; m < pairs; m++)
                    begin
                        found = 1'b0;
                        best  = '0;
                        bi    = 0;
                        bj    = 0;
                        for (int i = 0; i < n_obs; i++)
                            for (int j = 0; j < n_trk; j++)
                                if (!obs_taken[i] && !trk_taken[j] &&
                                    (!found || pair_cost[i][j] < best))
                                begin
                                    found = 1'b1;
                                    best  = pair_cost[i][j];
                                    bi    = i;
                                    bj    = j;
                                end
                        if (!found || best > dist_limit)
                            break;
                        obs_taken[bi] = 1'b1;
                        trk_taken[bj] = 1'b1;
                        run_q.insert(run_q.size(), mk_result(gnpm_pkg::KIND_MATCH, bi, bj));
                        n_matches++;
                    end
                    for (int j = 0; j < n_trk; j++)
                        if (!trk_taken[j])
                            run_q.insert(run_q.size(), mk_result(gnpm_pkg::KIND_TRACK, 0, j));
                    for (int i = 0; i < n_obs; i++)
                        if (!obs_taken[i])
                            run_q.insert(run_q.size(), mk_result(gnpm_pkg::KIND_OBS, i, 0));
                end
                run_q[run_q.size() - 1].last = 1'b1;
                foreach (run_q[k])
                    pending_results.insert(pending_results.size(), run_q[k]);
                n_obs   = 0;
                n_trk   = 0;
                dropped = 1'b0;
            end
            default: ;
        endcase
    endtask

    // input side: predict on every accepted beat
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            match_step(s_tuser, s_tdata);
    end

    // output side: compare every accepted beat
    always @(posedge clk)
    begin
        gnpm_pkg::result_t got;
        gnpm_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind        = m_tuser;
            got.obs_index   = m_tdata[3:0];
            got.track_index = m_tdata[6:4];
            got.overflow    = m_tdata[7];
            got.last        = m_tlast;
            n_results++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected beat", got, '0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                    report_mismatch("vs matcher", got, want);
            end
            if (got.last && typed_results.size() != 0)
            begin
                want = typed_results.pop_front();
                if (got !== want)
                    report_mismatch("vs table", got, want);
            end
        end
    end

    // receiver with random idling and a long hold-off on request
    always @(posedge clk)
    begin
        int hold_left;
        if (!rst_n)
        begin
            hold_left = 0;
            m_tready <= 1'b0;
        end
        else if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= DOG_MAX)
        begin
            $display("watchdog: no beat for %0d cycles", DOG_MAX);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_beat(input gnpm_pkg::req_t req, input logic [15:0] px,
                             input logic [15:0] py, input logic [15:0] ex,
                             input logic [15:0] ey);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {ey, ex, py, px};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(input logic [33:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dist_limit = v;
    endtask

    function automatic logic [15:0] near(input logic [15:0] c, input int spread);
        if ($urandom_range(7) == 0)
            return 16'($urandom);
        return c + 16'($urandom_range(2 * spread) - spread);
    endfunction

    // one well-formed group of loads followed by a run, with some noise
    task automatic random_group(input int max_o, input int max_t, output int sent);
        logic [15:0] cx, cy;
        int no, nt, spread;
        no     = $urandom_range(max_o);
        nt     = $urandom_range(max_t);
        spread = ($urandom_range(1)) ? 8 : 200;
        cx     = 16'($urandom);
        cy     = 16'($urandom);
        sent   = 0;
        while (no > 0 || nt > 0)
        begin
            if ($urandom_range(19) == 0)
            begin
                send_beat(gnpm_pkg::REQ_NONE, 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom));
                sent++;
            end
            if (no > 0 && (nt == 0 || $urandom_range(1)))
            begin
                send_beat(gnpm_pkg::REQ_LOAD_OBS, near(cx, spread), near(cy, spread),
                          16'($urandom), 16'($urandom));
                no--;
            end
            else
            begin
                send_beat(gnpm_pkg::REQ_LOAD_TRACK, near(cx, spread), near(cy, spread),
                          near(cx, spread), near(cy, spread));
                nt--;
            end
            sent++;
        end
        send_beat(gnpm_pkg::REQ_RUN, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
        sent++;
    endtask

    stim_row_t directed [] = '{
        '{gnpm_pkg::REQ_RUN,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1'b1,
          '{gnpm_pkg::KIND_EMPTY, 4'd0, 3'd0, 1'b0, 1'b1}},
        '{gnpm_pkg::REQ_NONE,       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b0, '0},
        '{gnpm_pkg::REQ_LOAD_OBS,   16'h8000, 16'h8000, 16'h0000, 16'h0000, 1, 1'b0, '0},
        '{gnpm_pkg::REQ_LOAD_TRACK, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1, 1'b0, '0},
        '{gnpm_pkg::REQ_RUN,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1'b1,
          '{gnpm_pkg::KIND_MATCH, 4'd0, 3'd0, 1'b0, 1'b1}},
        '{gnpm_pkg::REQ_LOAD_OBS,   16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1, 1'b0, '0},
        '{gnpm_pkg::REQ_RUN,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1'b1,
          '{gnpm_pkg::KIND_OBS, 4'd0, 3'd0, 1'b0, 1'b1}},
        '{gnpm_pkg::REQ_LOAD_TRACK, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1, 1'b0, '0},
        '{gnpm_pkg::REQ_RUN,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1'b1,
          '{gnpm_pkg::KIND_TRACK, 4'd0, 3'd0, 1'b0, 1'b1}},
        // far apart pair stays unmatched at the default limit
        '{gnpm_pkg::REQ_LOAD_OBS,   16'h8000, 16'h8000, 16'h0000, 16'h0000, 1, 1'b0, '0},
        '{gnpm_pkg::REQ_LOAD_TRACK, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1'b0, '0},
        '{gnpm_pkg::REQ_RUN,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1'b0, '0},
        // full tables with all costs tied, extra loads dropped
        '{gnpm_pkg::REQ_LOAD_OBS,   16'h0010, 16'hFFF0, 16'h0000, 16'h0000, 17, 1'b0, '0},
        '{gnpm_pkg::REQ_LOAD_TRACK, 16'h0010, 16'hFFF0, 16'h8000, 16'h7FFF, 9, 1'b0, '0},
        '{gnpm_pkg::REQ_RUN,        16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1'b0, '0}
    };

    initial
    begin
        int sent, total;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = gnpm_pkg::REQ_NONE;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        m_tready   = 1'b0;
        hold_req   = 0;
        idle_cycles = 0;
        errors     = 0;
        n_runs     = 0;
        n_results  = 0;
        n_matches  = 0;
        n_obs      = 0;
        n_trk      = 0;
        dropped    = 1'b0;
        dist_limit = 34'd256;
        tx_idle_pct = 38;
        rx_idle_pct = 65;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            if (directed[r].typed)
            begin
                wait_drained();
                typed_results.insert(typed_results.size(), directed[r].res);
            end
            repeat (directed[r].rep)
                send_beat(directed[r].req, directed[r].px, directed[r].py,
                          directed[r].ex, directed[r].ey);
        end
        // tied costs once more with every pair inside the widest limit
        write_limit(LIMIT_MAX);
        foreach (directed[r])
            if (r >= 12)
                repeat (directed[r].rep)
                    send_beat(directed[r].req, directed[r].px, directed[r].py,
                              directed[r].ex, directed[r].ey);

        total = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 65 : 0;
            rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 38 : 0;
            for (int grp = 0; grp < 6; grp++)
            begin
                case ($urandom_range(3))
                    0: write_limit('0);
                    1: write_limit(LIMIT_MAX);
                    2: write_limit(34'($urandom_range(4096)));
                    default: write_limit({2'($urandom), 32'($urandom)});
                endcase
                for (int k = 0; k < 3; k++)
                begin
                    // big group behind a long receiver hold-off
                    if (phase == 1 && grp == 0 && k == 0)
                    begin
                        hold_req = 400;
                        random_group(20, 10, sent);
                        total += sent;
                        random_group(20, 10, sent);
                    end
                    else if ($urandom_range(9) == 0)
                        random_group(20, 10, sent);
                    else
                        random_group(6, 4, sent);
                    total += sent;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d random beats, %0d runs, %0d result beats, %0d matches",
                 total, n_runs, n_results, n_matches);
        $display("limits from zero to full width, tied costs, table overflow and empty runs");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/gnpm_pkg.sv
rtl/gnpm_ram.sv
rtl/gnpm_out_reg.sv
rtl/greedy_nearest_pair_matcher.sv
rtl/gnpm_checker.sv
verif/greedy_nearest_pair_matcher_test.sv
